// ===== src/pyr_pkg.sv =====
// ----------------------------------------------------------------------------
// pyr_pkg
// Shared constants, types and address helpers of the image pyramid block.
// ----------------------------------------------------------------------------
package pyr_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int LEVELS     = 6;

   localparam int LVL_BITS  = 3;
   localparam int X_BITS    = 10;
   localparam int Y_BITS    = 10;
   localparam int DIM_BITS  = 11;
   localparam int PIX_BITS  = 8;
   localparam int INT_BITS  = 18;
   localparam int FRAC_BITS = 10;
   localparam int GRAD_BITS = 20;
   localparam int SQ_BITS   = 39;
   localparam int PSUM_BITS = 20;

   localparam int HIST_DEPTH = 4 * MAX_WIDTH + 2 * LEVELS;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int RING_BITS  = $clog2(2 * MAX_WIDTH + 3);
   localparam int PAIR_DEPTH = MAX_WIDTH;
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;

   localparam int OPQ_DEPTH  = 4;
   localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_LEVELS_USED  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OP,
      ST_MERGE
   } state_type;

   // one level step handed from the front to the back
   typedef struct packed {
      logic [LVL_BITS-1:0] lvl;
      logic [X_BITS-1:0]   x;
      logic [Y_BITS-1:0]   y;
      logic [INT_BITS-1:0] val;
      logic [HIST_AW-1:0]  wr_addr;
      logic [HIST_AW-1:0]  ur_addr;
      logic [HIST_AW-1:0]  uu_addr;
      logic                narrow;
      logic                emit_up;
      logic                grad_ok;
      logic                emit_row;
      logic                last;
   } op_type;

   typedef struct packed {
      logic [LVL_BITS-1:0]         level;
      logic [X_BITS-1:0]           x_pos;
      logic [Y_BITS-1:0]           y_pos;
      logic [INT_BITS-1:0]         intensity;
      logic signed [GRAD_BITS-1:0] grad_x;
      logic signed [GRAD_BITS-1:0] grad_y;
      logic [SQ_BITS-1:0]          grad_sq;
      logic                        grad_valid;
      logic                        last;
   } rsp_type;

   // start of the history ring of a level
   function automatic logic [HIST_AW-1:0] hist_base(input logic [LVL_BITS-1:0] l);
      int b;
      b = 0;
      for (int k = 0; k < LEVELS; k++) begin
         if (k < int'(l)) b += 2 * (MAX_WIDTH >> k) + 2;
      end
      return HIST_AW'(b);
   endfunction

   // start of the pair sum row of a level (level one and up)
   function automatic logic [PAIR_AW-1:0] pair_base(input logic [LVL_BITS-1:0] l);
      int b;
      b = 0;
      for (int k = 1; k < LEVELS; k++) begin
         if (k < int'(l)) b += (MAX_WIDTH / 2) >> (k - 1);
      end
      return PAIR_AW'(b);
   endfunction

endpackage

// ===== src/pyr_ram.sv =====
// ----------------------------------------------------------------------------
// pyr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pyr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pyr_front.sv =====
// ----------------------------------------------------------------------------
// pyr_front
// Accepts pixels, walks the level cascade and issues one step per level.
// ----------------------------------------------------------------------------
module pyr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [pyr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pyr_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                              req_push,
   input  logic [pyr_pkg::PIX_BITS-1:0]      req_pixel,
   output logic                              req_full,
   input  logic                              q_full,
   output logic                              q_push,
   output pyr_pkg::op_type                   q_op
);

   localparam int NL = pyr_pkg::LEVELS;
   localparam int DB = pyr_pkg::DIM_BITS;
   localparam int XB = pyr_pkg::X_BITS;
   localparam int YB = pyr_pkg::Y_BITS;
   localparam int LB = pyr_pkg::LVL_BITS;
   localparam int IB = pyr_pkg::INT_BITS;
   localparam int HA = pyr_pkg::HIST_AW;
   localparam int RB = pyr_pkg::RING_BITS;
   localparam int PB = pyr_pkg::PSUM_BITS;

   // configuration
   logic [DB-1:0] width_ff, width_in, height_ff, height_in;
   logic [LB-1:0] levels_ff, levels_in;
   logic          cfg_hit;

   // per level position
   logic [XB-1:0] cx_ff [NL];
   logic [XB-1:0] cx_in [NL];
   logic [YB-1:0] cy_ff [NL];
   logic [YB-1:0] cy_in [NL];
   logic [RB-1:0] ptr_ff [NL];
   logic [RB-1:0] ptr_in [NL];
   logic [IB-1:0] prev_ff [NL];
   logic [IB-1:0] prev_in [NL];

   pyr_pkg::state_type state_ff, state_in;
   logic [LB-1:0] lvl_ff, lvl_in;
   logic [IB-1:0] val_ff, val_in;
   logic [PB-1:0] sum_ff, sum_in;
   logic [LB-1:0] last_lvl_ff, last_lvl_in;
   logic          last_any_ff, last_any_in;
   logic          frame_end_ff, frame_end_in;

   // geometry
   logic [DB-1:0] fw, fh;
   logic [DB-1:0] lw [NL+1];
   logic [DB-1:0] lh [NL+1];
   logic [LB-1:0] nl;
   logic [XB-1:0] nx [NL];
   logic [YB-1:0] ny [NL];
   logic [NL-1:0] nrm, emits, cont;
   logic [NL:0]   reached;
   logic [LB-1:0] comb_last_lvl;
   logic          comb_last_any;

   // current step
   logic [XB-1:0] cur_x;
   logic [YB-1:0] cur_y;
   logic [DB-1:0] cur_w, cur_h;
   logic [RB-1:0] cur_ptr, ring_size, ptr_next;
   logic          cur_cont;
   logic [DB-1:0] x_inc, y_inc;
   logic          wrap_x, wrap_y;
   logic [XB-1:0] x_next;
   logic [YB-1:0] y_next;
   logic [HA-1:0] off_ur, off_uu, rel_ur, rel_uu, ptr_ext, size_ext;
   logic [PB-1:0] pair_sum;
   logic [pyr_pkg::PAIR_AW-1:0] pair_addr;
   logic [PB-1:0] pair_rd;
   logic [PB:0]   merge_sum;
   logic          frame_end_now;

   // handshake and control
   logic fire, finish, accept, pair_wr, pair_rd_en;

   always_comb begin
      cfg_hit   = 1'b0;
      width_in  = width_ff;
      height_in = height_ff;
      levels_in = levels_ff;
      if (csr_write_en) begin
         case (pyr_pkg::csr_index_type'(csr_index))
            pyr_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_wdata;
               cfg_hit  = 1'b1;
            end
            pyr_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata;
               cfg_hit   = 1'b1;
            end
            pyr_pkg::CSR_LEVELS_USED: begin
               levels_in = csr_wdata[LB-1:0];
               cfg_hit   = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   always_comb begin
      logic [LB-1:0] n;
      if (width_ff == '0) fw = DB'(1);
      else if (width_ff > DB'(pyr_pkg::MAX_WIDTH)) fw = DB'(pyr_pkg::MAX_WIDTH);
      else fw = width_ff;
      if (height_ff == '0) fh = DB'(1);
      else if (height_ff > DB'(pyr_pkg::MAX_HEIGHT)) fh = DB'(pyr_pkg::MAX_HEIGHT);
      else fh = height_ff;
      for (int k = 0; k <= NL; k++) begin
         lw[k] = fw >> k;
         lh[k] = fh >> k;
      end
      if (levels_ff == '0) n = LB'(1);
      else if (levels_ff > LB'(NL)) n = LB'(NL);
      else n = levels_ff;
      nl = n;
      // first level that collapses to nothing caps the count
      for (int k = NL - 1; k >= 1; k--) begin
         if (k < int'(n) && (lw[k] == '0 || lh[k] == '0)) nl = LB'(k);
      end
   end

   // which levels this pixel reaches and which of them give results
   always_comb begin
      reached[0]    = 1'b1;
      comb_last_lvl = '0;
      comb_last_any = 1'b0;
      for (int k = 0; k < NL; k++) begin
         nrm[k] = ({1'b0, cx_ff[k]} >= lw[k]) || ({1'b0, cy_ff[k]} >= lh[k]);
         nx[k]  = nrm[k] ? '0 : cx_ff[k];
         ny[k]  = nrm[k] ? '0 : cy_ff[k];
         emits[k] = reached[k] && (ny[k] != '0 || {1'b0, ny[k]} == lh[k] - DB'(1));
         cont[k]  = (k + 1 < int'(nl)) && nx[k][0] &&
                    (DB'(nx[k] >> 1) < lw[k+1]) && (DB'(ny[k] >> 1) < lh[k+1]);
         reached[k+1] = reached[k] && cont[k] && ny[k][0];
         if (emits[k]) begin
            comb_last_lvl = LB'(k);
            comb_last_any = 1'b1;
         end
      end
   end

   always_comb begin
      cur_x     = nx[lvl_ff];
      cur_y     = ny[lvl_ff];
      cur_w     = lw[lvl_ff];
      cur_h     = lh[lvl_ff];
      cur_cont  = cont[lvl_ff];
      cur_ptr   = nrm[lvl_ff] ? '0 : ptr_ff[lvl_ff];
      ring_size = RB'({cur_w, 1'b0}) + RB'(2);

      x_inc  = {1'b0, cur_x} + DB'(1);
      wrap_x = x_inc == cur_w;
      y_inc  = {1'b0, cur_y} + DB'(1);
      wrap_y = wrap_x && (y_inc == cur_h);
      x_next = wrap_x ? '0 : x_inc[XB-1:0];
      y_next = wrap_y ? '0 : (wrap_x ? y_inc[YB-1:0] : cur_y);

      if (wrap_y) ptr_next = '0;
      else if (cur_ptr + RB'(1) == ring_size) ptr_next = '0;
      else ptr_next = cur_ptr + RB'(1);

      // ring offsets of the pixel up-right and two rows up
      ptr_ext  = HA'(cur_ptr);
      size_ext = HA'(ring_size);
      off_ur   = HA'(cur_w) - HA'(1);
      off_uu   = HA'({cur_w, 1'b0});
      rel_ur   = (ptr_ext >= off_ur) ? ptr_ext - off_ur : ptr_ext + size_ext - off_ur;
      rel_uu   = (ptr_ext >= off_uu) ? ptr_ext - off_uu : ptr_ext + size_ext - off_uu;

      pair_sum  = PB'(val_ff) + PB'(prev_ff[lvl_ff]);
      pair_addr = pyr_pkg::pair_base(lvl_ff + LB'(1)) +
                  pyr_pkg::PAIR_AW'(cur_x >> 1);
      merge_sum = {1'b0, pair_rd} + {1'b0, sum_ff};
   end

   // FSM outputs
   always_comb begin
      fire       = (state_ff == pyr_pkg::ST_OP) && !q_full;
      finish     = fire && !(cur_cont && cur_y[0]);
      pair_wr    = fire && cur_cont && !cur_y[0];
      pair_rd_en = fire && cur_cont && cur_y[0];
      req_full   = !((state_ff == pyr_pkg::ST_IDLE) || finish);
      accept     = req_push && !req_full;
      q_push     = fire;
      frame_end_now = fire && (lvl_ff == '0) && wrap_y;
   end

   // FSM next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pyr_pkg::ST_IDLE: begin
            if (accept) state_in = pyr_pkg::ST_OP;
         end
         pyr_pkg::ST_OP: begin
            if (finish) state_in = accept ? pyr_pkg::ST_OP : pyr_pkg::ST_IDLE;
            else if (pair_rd_en) state_in = pyr_pkg::ST_MERGE;
         end
         pyr_pkg::ST_MERGE: state_in = pyr_pkg::ST_OP;
         default: state_in = pyr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      logic [LB-1:0] ll;
      logic          la;
      ll = (lvl_ff == '0) ? comb_last_lvl : last_lvl_ff;
      la = (lvl_ff == '0) ? comb_last_any : last_any_ff;
      q_op.lvl      = lvl_ff;
      q_op.x        = cur_x;
      q_op.y        = cur_y;
      q_op.val      = val_ff;
      q_op.wr_addr  = pyr_pkg::hist_base(lvl_ff) + ptr_ext;
      q_op.ur_addr  = pyr_pkg::hist_base(lvl_ff) + rel_ur;
      q_op.uu_addr  = pyr_pkg::hist_base(lvl_ff) + rel_uu;
      q_op.narrow   = cur_w == DB'(1);
      q_op.emit_up  = cur_y != '0;
      q_op.grad_ok  = cur_y > YB'(1);
      q_op.emit_row = {1'b0, cur_y} == cur_h - DB'(1);
      q_op.last     = la && (lvl_ff == ll);
   end

   always_comb begin
      lvl_in       = lvl_ff;
      val_in       = val_ff;
      sum_in       = sum_ff;
      last_lvl_in  = last_lvl_ff;
      last_any_in  = last_any_ff;
      frame_end_in = frame_end_ff || frame_end_now;
      for (int k = 0; k < NL; k++) begin
         cx_in[k]   = cx_ff[k];
         cy_in[k]   = cy_ff[k];
         ptr_in[k]  = ptr_ff[k];
         prev_in[k] = prev_ff[k];
      end
      if (fire) begin
         cx_in[lvl_ff]   = x_next;
         cy_in[lvl_ff]   = y_next;
         ptr_in[lvl_ff]  = ptr_next;
         prev_in[lvl_ff] = val_ff;
         if (lvl_ff == '0) begin
            last_lvl_in = comb_last_lvl;
            last_any_in = comb_last_any;
         end
      end
      if (pair_rd_en) sum_in = pair_sum;
      if (state_ff == pyr_pkg::ST_MERGE) begin
         val_in = IB'(merge_sum >> 2);
         lvl_in = lvl_ff + LB'(1);
      end
      // restart every level once the frame is complete, or on a write to a listed register
      if ((finish && (frame_end_ff || frame_end_now)) || cfg_hit) begin
         for (int k = 0; k < NL; k++) begin
            cx_in[k]  = '0;
            cy_in[k]  = '0;
            ptr_in[k] = '0;
         end
      end
      if (accept) begin
         lvl_in       = '0;
         val_in       = IB'(req_pixel) << pyr_pkg::FRAC_BITS;
         frame_end_in = 1'b0;
      end
   end

   pyr_ram #(
      .WIDTH(PB),
      .DEPTH(pyr_pkg::PAIR_DEPTH)
   ) u_pair_ram (
      .clock  (clock),
      .wr_en  (pair_wr),
      .wr_addr(pair_addr),
      .wr_data(pair_sum),
      .rd_en  (pair_rd_en),
      .rd_addr(pair_addr),
      .rd_data(pair_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DB'(640);
         height_ff    <= DB'(480);
         levels_ff    <= LB'(6);
         state_ff     <= pyr_pkg::ST_IDLE;
         frame_end_ff <= 1'b0;
         last_any_ff  <= 1'b0;
         last_lvl_ff  <= '0;
         lvl_ff       <= '0;
         for (int k = 0; k < NL; k++) begin
            cx_ff[k]  <= '0;
            cy_ff[k]  <= '0;
            ptr_ff[k] <= '0;
         end
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         levels_ff    <= levels_in;
         state_ff     <= state_in;
         frame_end_ff <= frame_end_in;
         last_any_ff  <= last_any_in;
         last_lvl_ff  <= last_lvl_in;
         lvl_ff       <= lvl_in;
         for (int k = 0; k < NL; k++) begin
            cx_ff[k]  <= cx_in[k];
            cy_ff[k]  <= cy_in[k];
            ptr_ff[k] <= ptr_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      sum_ff <= sum_in;
      for (int k = 0; k < NL; k++) begin
         prev_ff[k] <= prev_in[k];
      end
   end

endmodule

// ===== src/pyr_op_queue.sv =====
// ----------------------------------------------------------------------------
// pyr_op_queue
// Short queue of level steps between the front and the back.
// ----------------------------------------------------------------------------
module pyr_op_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  pyr_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output pyr_pkg::op_type head_op
);

   localparam int AW = pyr_pkg::OPQ_AW;

   pyr_pkg::op_type slot_ff [pyr_pkg::OPQ_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   always_comb begin
      full      = count_ff == (AW + 1)'(pyr_pkg::OPQ_DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
      head_op   = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_op;
   end

endmodule

// ===== src/pyr_back.sv =====
// ----------------------------------------------------------------------------
// pyr_back
// Keeps the row history, forms gradients and queues the result beats.
// ----------------------------------------------------------------------------
module pyr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  pyr_pkg::op_type  q_op,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output pyr_pkg::rsp_type rsp
);

   localparam int NL = pyr_pkg::LEVELS;
   localparam int IB = pyr_pkg::INT_BITS;
   localparam int GB = pyr_pkg::GRAD_BITS;
   localparam int SB = pyr_pkg::SQ_BITS;
   localparam int QA = pyr_pkg::RSPQ_AW;

   logic adv, fire_a;
   logic [IB-1:0] ur_rd, uu_rd;

   // stage after the history read
   logic            s1_vld_ff, s1_vld_in;
   pyr_pkg::op_type op1_ff;
   logic [IB-1:0]   chain_a_ff [NL];
   logic [IB-1:0]   chain_b_ff [NL];
   logic [IB-1:0]   upr, above, above_left;
   logic signed [GB-1:0] gx, gy;

   // stage before the squares
   logic            s2_vld_ff, s2_vld_in;
   pyr_pkg::op_type op2_ff;
   logic [IB-1:0]   c2_ff;
   logic signed [GB-1:0] gx2_ff, gy2_ff;

   // emit stage
   logic            s3_vld_ff, s3_vld_in;
   pyr_pkg::op_type op3_ff;
   logic [IB-1:0]   c3_ff;
   logic signed [GB-1:0] gx3_ff, gy3_ff;
   logic [SB-1:0]   sqx_ff, sqy_ff;
   logic signed [2*GB-1:0] sqx_full, sqy_full;
   logic            done_a_ff, done_a_in;
   logic            need_a, need_b, d_done, q_wr;
   pyr_pkg::rsp_type beat;

   // result queue
   pyr_pkg::rsp_type rq_ff [pyr_pkg::RSPQ_DEPTH];
   logic [QA-1:0]    rq_wr_ff, rq_wr_in, rq_rd_ff, rq_rd_in;
   logic [QA:0]      rq_cnt_ff, rq_cnt_in;
   logic             rq_full, do_pop;

   always_comb begin
      rq_full = rq_cnt_ff == (QA + 1)'(pyr_pkg::RSPQ_DEPTH);
      need_a  = op3_ff.emit_up && !done_a_ff;
      need_b  = op3_ff.emit_row;
      q_wr    = 1'b0;
      d_done  = 1'b0;
      done_a_in = done_a_ff;
      beat.level      = op3_ff.lvl;
      beat.x_pos      = op3_ff.x;
      beat.y_pos      = op3_ff.y - pyr_pkg::Y_BITS'(1);
      beat.intensity  = c3_ff;
      beat.grad_x     = gx3_ff;
      beat.grad_y     = gy3_ff;
      beat.grad_sq    = sqx_ff + sqy_ff;
      beat.grad_valid = op3_ff.grad_ok;
      beat.last       = op3_ff.last && !need_b;
      if (!s3_vld_ff) begin
         d_done = 1'b0;
      end else if (!need_a && !need_b) begin
         d_done = 1'b1;
      end else if (!rq_full) begin
         q_wr = 1'b1;
         if (need_a) begin
            d_done    = !need_b;
            done_a_in = need_b;
         end else begin
            beat.y_pos      = op3_ff.y;
            beat.intensity  = op3_ff.val;
            beat.grad_x     = '0;
            beat.grad_y     = '0;
            beat.grad_sq    = '0;
            beat.grad_valid = 1'b0;
            beat.last       = op3_ff.last;
            d_done          = 1'b1;
         end
      end
      if (d_done) done_a_in = 1'b0;
      adv    = !s3_vld_ff || d_done;
      fire_a = adv && !q_empty;
      q_pop  = fire_a;
   end

   pyr_ram #(
      .WIDTH(IB),
      .DEPTH(pyr_pkg::HIST_DEPTH)
   ) u_hist_ur (
      .clock  (clock),
      .wr_en  (fire_a),
      .wr_addr(q_op.wr_addr),
      .wr_data(q_op.val),
      .rd_en  (fire_a),
      .rd_addr(q_op.ur_addr),
      .rd_data(ur_rd)
   );

   pyr_ram #(
      .WIDTH(IB),
      .DEPTH(pyr_pkg::HIST_DEPTH)
   ) u_hist_uu (
      .clock  (clock),
      .wr_en  (fire_a),
      .wr_addr(q_op.wr_addr),
      .wr_data(q_op.val),
      .rd_en  (fire_a),
      .rd_addr(q_op.uu_addr),
      .rd_data(uu_rd)
   );

   always_comb begin
      // a one pixel wide level sees itself as the pixel up-right
      upr        = op1_ff.narrow ? op1_ff.val : ur_rd;
      above      = chain_a_ff[op1_ff.lvl];
      above_left = chain_b_ff[op1_ff.lvl];
      gx = op1_ff.grad_ok ? GB'(upr) - GB'(above_left) : '0;
      gy = op1_ff.grad_ok ? GB'(op1_ff.val) - GB'(uu_rd) : '0;
      sqx_full = gx2_ff * gx2_ff;
      sqy_full = gy2_ff * gy2_ff;
      s1_vld_in = adv ? fire_a : s1_vld_ff;
      s2_vld_in = adv ? s1_vld_ff : s2_vld_ff;
      s3_vld_in = adv ? s2_vld_ff : s3_vld_ff;
   end

   always_comb begin
      do_pop    = rsp_pop && !rsp_empty;
      rq_wr_in  = q_wr ? rq_wr_ff + QA'(1) : rq_wr_ff;
      rq_rd_in  = do_pop ? rq_rd_ff + QA'(1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff + (QA + 1)'(q_wr) - (QA + 1)'(do_pop);
      rsp_empty = rq_cnt_ff == '0;
      rsp       = rq_ff[rq_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         done_a_ff <= 1'b0;
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         done_a_ff <= done_a_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff <= q_op;
         op2_ff <= op1_ff;
         c2_ff  <= above;
         gx2_ff <= gx;
         gy2_ff <= gy;
         op3_ff <= op2_ff;
         c3_ff  <= c2_ff;
         gx3_ff <= gx2_ff;
         gy3_ff <= gy2_ff;
         sqx_ff <= sqx_full[SB-1:0];
         sqy_ff <= sqy_full[SB-1:0];
         // advance the row-above window of this level
         if (s1_vld_ff) begin
            chain_b_ff[op1_ff.lvl] <= above;
            chain_a_ff[op1_ff.lvl] <= upr;
         end
      end
      if (q_wr) rq_ff[rq_wr_ff] <= beat;
   end

endmodule

// ===== src/image_pyramid_gradient.sv =====
// ----------------------------------------------------------------------------
// image_pyramid_gradient
// Streaming box-filter image pyramid with central difference gradients.
// ----------------------------------------------------------------------------
// Pixels of level 0 enter in raster order on the req_ queue port: a beat is
// taken when req_push is high and req_full is low. Each pixel yields from
// zero up to twelve result beats on the rsp_ queue port, levels in
// ascending order, the final one of the pixel flagged by rsp_last. A beat is
// shown while rsp_empty is low and taken when rsp_pop is high.
// A pixel holds the input while the front walks the levels it reaches:
// each further level it completes adds a pair sum read and a merge step
// before its level step is issued. The back takes one level step per
// cycle while its emit stage is not held by a second beat or a full result
// queue, and the single result port one beat per cycle, against about 1.3
// beats per pixel. Results pass through the step queue, the stage after
// the history read, the stage before the squares, the emit stage and the
// result queue.
// A slow receiver fills the result queue, then the step queue, and then
// req_full rises; nothing is dropped.
// Reset restores 640 x 480 with six levels and starts at pixel (0,0); any
// csr_ write to a listed register also restarts the frame. No clearing
// pass is needed since the history is always written before it is read.
// ----------------------------------------------------------------------------
module image_pyramid_gradient (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [pyr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pyr_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                req_push,
   input  logic [pyr_pkg::PIX_BITS-1:0]        req_pixel,
   output logic                                req_full,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output logic [pyr_pkg::LVL_BITS-1:0]        rsp_level,
   output logic [pyr_pkg::X_BITS-1:0]          rsp_x_pos,
   output logic [pyr_pkg::Y_BITS-1:0]          rsp_y_pos,
   output logic [pyr_pkg::INT_BITS-1:0]        rsp_intensity,
   output logic [pyr_pkg::PIX_BITS-1:0]        rsp_gray_byte,
   output logic signed [pyr_pkg::GRAD_BITS-1:0] rsp_grad_x,
   output logic signed [pyr_pkg::GRAD_BITS-1:0] rsp_grad_y,
   output logic [pyr_pkg::SQ_BITS-1:0]         rsp_grad_sq,
   output logic                                rsp_grad_valid,
   output logic                                rsp_last
);

   logic             q_full, q_push, q_empty, q_pop;
   pyr_pkg::op_type  push_op, head_op;
   pyr_pkg::rsp_type rsp;

   pyr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_push    (req_push),
      .req_pixel   (req_pixel),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_op        (push_op)
   );

   pyr_op_queue u_op_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .push_op(push_op),
      .full   (q_full),
      .pop    (q_pop),
      .empty  (q_empty),
      .head_op(head_op)
   );

   pyr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_op     (head_op),
      .q_pop    (q_pop),
      .rsp_pop  (rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp      (rsp)
   );

   assign rsp_level      = rsp.level;
   assign rsp_x_pos      = rsp.x_pos;
   assign rsp_y_pos      = rsp.y_pos;
   assign rsp_intensity  = rsp.intensity;
   assign rsp_gray_byte  = rsp.intensity[pyr_pkg::INT_BITS-1:pyr_pkg::FRAC_BITS];
   assign rsp_grad_x     = rsp.grad_x;
   assign rsp_grad_y     = rsp.grad_y;
   assign rsp_grad_sq    = rsp.grad_sq;
   assign rsp_grad_valid = rsp.grad_valid;
   assign rsp_last       = rsp.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the image pyramid gradient block: a pyramid
// predictor works out the result beats of every accepted pixel, and each
// result beat taken from the block is compared field by field, in order.
// ----------------------------------------------------------------------------

typedef struct {
   logic [2:0]  level;
   logic [9:0]  x_pos;
   logic [9:0]  y_pos;
   logic [17:0] intensity;
   logic [7:0]  gray_byte;
   logic [19:0] grad_x;
   logic [19:0] grad_y;
   logic [38:0] grad_sq;
   logic        grad_valid;
   logic        last;
} pyr_beat_type;

class pyramid_scoreboard;
   localparam int HDEPTH = pyr_pkg::HIST_DEPTH;
   localparam int MAXW   = pyr_pkg::MAX_WIDTH;
   localparam int NLVL   = pyr_pkg::LEVELS;

   int unsigned  history[HDEPTH];
   int unsigned  pair_row[NLVL][MAXW/2+1];
   int unsigned  col_at[NLVL];
   int unsigned  row_at[NLVL];
   int unsigned  frame_w, frame_h, depth_cfg;
   pyr_beat_type awaited[$];
   int           errors;

   function new();
      foreach (history[i]) history[i] = 0;
      foreach (pair_row[i, j]) pair_row[i][j] = 0;
      restart();
      frame_w = 640;
      frame_h = 480;
      depth_cfg = 6;
      errors = 0;
   endfunction

   function void restart();
      foreach (col_at[i]) begin
         col_at[i] = 0;
         row_at[i] = 0;
      end
   endfunction

   function void write_reg(pyr_pkg::csr_index_type idx, int unsigned val);
      case (idx)
         pyr_pkg::CSR_FRAME_WIDTH:  frame_w = val & 11'h7ff;
         pyr_pkg::CSR_FRAME_HEIGHT: frame_h = val & 11'h7ff;
         pyr_pkg::CSR_LEVELS_USED:  depth_cfg = val & 3'h7;
         default: return;
      endcase
      restart();
   endfunction

   function int unsigned lvl_w(int unsigned l);
      int unsigned w;
      w = frame_w < 1 ? 1 : (frame_w > MAXW ? MAXW : frame_w);
      return w >> l;
   endfunction

   function int unsigned lvl_h(int unsigned l);
      int unsigned h;
      h = frame_h < 1 ? 1 : (frame_h > pyr_pkg::MAX_HEIGHT ? pyr_pkg::MAX_HEIGHT : frame_h);
      return h >> l;
   endfunction

   function int unsigned active_levels();
      int unsigned n;
      n = depth_cfg < 1 ? 1 : (depth_cfg > NLVL ? NLVL : depth_cfg);
      for (int unsigned l = 1; l < n; l++)
         if (lvl_w(l) == 0 || lvl_h(l) == 0) return l;
      return n;
   endfunction

   // ring entry written `back` pixels before linear index lin
   function int unsigned ring_slot(int unsigned l, int unsigned lin, int unsigned back);
      int unsigned base, size;
      base = 0;
      size = 2 * lvl_w(l) + 2;
      for (int unsigned k = 0; k < l; k++) base += 2 * (MAXW >> k) + 2;
      return base + ((lin % size) + size - back) % size;
   endfunction

   function pyr_beat_type make_beat(int unsigned l, int unsigned x, int unsigned y,
                                    int unsigned inten, longint gx, longint gy, bit ok);
      pyr_beat_type b;
      longint sq;
      if (!ok) begin
         gx = 0;
         gy = 0;
      end
      sq = gx * gx + gy * gy;
      b.level = l[2:0];
      b.x_pos = x[9:0];
      b.y_pos = y[9:0];
      b.intensity = inten[17:0];
      b.gray_byte = inten[17:10];
      b.grad_x = gx[19:0];
      b.grad_y = gy[19:0];
      b.grad_sq = sq[38:0];
      b.grad_valid = ok;
      b.last = 0;
      return b;
   endfunction

   function void note_pixel(logic [7:0] pix);
      int unsigned  v, nl, w, h, x, y, lin, nx, ny, up, s;
      bit           done, ok;
      longint       gx, gy;
      pyr_beat_type beats[$];
      v = int'(pix) << 10;
      nl = active_levels();
      done = 0;
      for (int unsigned l = 0; l < nl; l++) begin
         w = lvl_w(l);
         h = lvl_h(l);
         x = col_at[l];
         y = row_at[l];
         if (x >= w || y >= h) begin
            x = 0;
            y = 0;
         end
         lin = y * w + x;
         history[ring_slot(l, lin, 0)] = v;
         if (y >= 1) begin
            ok = y >= 2;
            up = history[ring_slot(l, lin, w)];
            gx = 0;
            gy = 0;
            if (ok) begin
               gx = longint'(history[ring_slot(l, lin, w - 1)])
                  - longint'(history[ring_slot(l, lin, w + 1)]);
               gy = longint'(v) - longint'(history[ring_slot(l, lin, 2 * w)]);
            end
            beats.push_back(make_beat(l, x, y - 1, up, gx, gy, ok));
         end
         if (y == h - 1) beats.push_back(make_beat(l, x, y, v, 0, 0, 0));
         nx = x + 1;
         ny = y;
         if (nx == w) begin
            nx = 0;
            ny = y + 1;
            if (ny == h) begin
               ny = 0;
               if (l == 0) done = 1;
            end
         end
         col_at[l] = nx;
         row_at[l] = ny;
         if (l + 1 < nl && x[0] && (x >> 1) < lvl_w(l + 1) && (y >> 1) < lvl_h(l + 1)) begin
            s = v + history[ring_slot(l, lin, 1)];
            if (!y[0]) begin
               pair_row[l + 1][x >> 1] = s;
               break;
            end
            v = (pair_row[l + 1][x >> 1] + s) >> 2;
         end else begin
            break;
         end
      end
      if (done) restart();
      if (beats.size() > 0) beats[beats.size() - 1].last = 1;
      foreach (beats[i]) awaited.push_back(beats[i]);
   endfunction

   function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
      errors++;
   endfunction

   function void check_beat(pyr_beat_type got);
      pyr_beat_type e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result beat, expected none actual level %0d x %0d y %0d",
                  $time, got.level, got.x_pos, got.y_pos);
         errors++;
         return;
      end
      e = awaited.pop_front();
      if (got.level !== e.level) flag("level", e.level, got.level);
      if (got.x_pos !== e.x_pos) flag("x_pos", e.x_pos, got.x_pos);
      if (got.y_pos !== e.y_pos) flag("y_pos", e.y_pos, got.y_pos);
      if (got.intensity !== e.intensity) flag("intensity", e.intensity, got.intensity);
      if (got.gray_byte !== e.gray_byte) flag("gray_byte", e.gray_byte, got.gray_byte);
      if (got.grad_x !== e.grad_x) flag("grad_x", e.grad_x, got.grad_x);
      if (got.grad_y !== e.grad_y) flag("grad_y", e.grad_y, got.grad_y);
      if (got.grad_sq !== e.grad_sq) flag("grad_sq", e.grad_sq, got.grad_sq);
      if (got.grad_valid !== e.grad_valid) flag("grad_valid", e.grad_valid, got.grad_valid);
      if (got.last !== e.last) flag("last", e.last, got.last);
   endfunction
endclass

module tb;

   localparam logic [pyr_pkg::CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                                 clock = 0;
   logic                                 reset = 1;
   logic                                 csr_write_en = 0;
   logic [pyr_pkg::CSR_IDX_BITS-1:0]     csr_index = '0;
   logic [pyr_pkg::CSR_DATA_BITS-1:0]    csr_wdata = '0;
   logic                                 req_push = 0;
   logic [pyr_pkg::PIX_BITS-1:0]         req_pixel = '0;
   logic                                 req_full;
   logic                                 rsp_pop = 0;
   logic                                 rsp_empty;
   logic [pyr_pkg::LVL_BITS-1:0]         rsp_level;
   logic [pyr_pkg::X_BITS-1:0]           rsp_x_pos;
   logic [pyr_pkg::Y_BITS-1:0]           rsp_y_pos;
   logic [pyr_pkg::INT_BITS-1:0]         rsp_intensity;
   logic [pyr_pkg::PIX_BITS-1:0]         rsp_gray_byte;
   logic signed [pyr_pkg::GRAD_BITS-1:0] rsp_grad_x;
   logic signed [pyr_pkg::GRAD_BITS-1:0] rsp_grad_y;
   logic [pyr_pkg::SQ_BITS-1:0]          rsp_grad_sq;
   logic                                 rsp_grad_valid;
   logic                                 rsp_last;

   pyramid_scoreboard pyramid = new();
   bit calm = 0;
   int pop_hold = 0;

   image_pyramid_gradient u_dut (.*);

   always #6 clock = ~clock;

   // result side: random stall bursts until the calm tail
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         pyr_beat_type b;
         b.level = rsp_level;
         b.x_pos = rsp_x_pos;
         b.y_pos = rsp_y_pos;
         b.intensity = rsp_intensity;
         b.gray_byte = rsp_gray_byte;
         b.grad_x = rsp_grad_x;
         b.grad_y = rsp_grad_y;
         b.grad_sq = rsp_grad_sq;
         b.grad_valid = rsp_grad_valid;
         b.last = rsp_last;
         pyramid.check_beat(b);
      end
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         pop_hold <= $urandom_range(0, 5);
         rsp_pop <= 0;
      end else begin
         rsp_pop <= 1;
      end
   end

   task automatic push_pixel(logic [7:0] pix);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push <= 1;
      req_pixel <= pix;
      do @(posedge clock); while (req_full);
      pyramid.note_pixel(pix);
   endtask

   // hold until every awaited beat is out, then let the pipeline settle
   task automatic drain();
      req_push <= 0;
      while (pyramid.awaited.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [pyr_pkg::CSR_IDX_BITS-1:0] idx, int unsigned val);
      drain();
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val[pyr_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write_en <= 0;
      pyramid.write_reg(pyr_pkg::csr_index_type'(idx), val);
   endtask

   task automatic setup(int unsigned w, int unsigned h, int unsigned lv);
      write_csr(pyr_pkg::CSR_FRAME_WIDTH, w);
      write_csr(pyr_pkg::CSR_FRAME_HEIGHT, h);
      write_csr(pyr_pkg::CSR_LEVELS_USED, lv);
   endtask

   task automatic random_pixels(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 9);
         push_pixel(sel == 0 ? 8'h00 : (sel == 1 ? 8'hff : 8'($urandom_range(0, 255))));
      end
   endtask

   initial begin
      #(12 * 3_000_000);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: tiny frame, extremes and alternation
      setup(4, 3, 2);
      for (int i = 0; i < 12; i++) push_pixel(i[0] ? 8'hff : 8'h00);
      for (int i = 0; i < 12; i++) push_pixel(8'(1 << (i % 8)));

      // spare index leaves the frame position alone
      write_csr(CSR_SPARE, 11'h7ff);
      random_pixels(6);

      setup(8, 8, 4);
      random_pixels(70);
      setup(2, 3, 1);
      random_pixels(12);
      setup(0, 0, 0);
      random_pixels(5);
      setup(12, 10, 3);
      random_pixels(60);
      setup(6, 2047, 7);
      random_pixels(30);
      setup(2047, 1, 6);
      random_pixels(20);
      setup(4, 4, 3);
      random_pixels(40);

      setup(16, 8, 5);
      calm = 1;
      random_pixels(140);

      drain();
      if (pyramid.errors == 0 && pyramid.awaited.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
